>>> src/svpss_pkg.sv
// ----------------------------------------------------------------------------
// svpss_pkg
// Shared types and constants for the servo pulse slew shaper.
// ----------------------------------------------------------------------------
package svpss_pkg;

  // internal pulse width: leaves room for rounding above the upper limit
  localparam int PW = 13;
  localparam int DIV_CW = $clog2(PW);

  // input command kinds
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // register indexes on the configuration port
  localparam logic [2:0] REG_HYST       = 3'd0;
  localparam logic [2:0] REG_QUANTUM    = 3'd1;
  localparam logic [2:0] REG_MAX_VEL    = 3'd2;
  localparam logic [2:0] REG_MAX_ACC    = 3'd3;
  localparam logic [2:0] REG_HOLD_BREAK = 3'd4;
  localparam logic [2:0] REG_HOLD_FRAME = 3'd5;
  localparam logic [2:0] REG_IDLE_FRAME = 3'd6;

  typedef struct packed {
    logic [9:0]  hysteresis_us;
    logic [7:0]  quantum_us;
    logic [7:0]  max_velocity_us;
    logic [7:0]  max_accel_us;
    logic [11:0] hold_break_us;
    logic [15:0] lock_frames;
    logic [15:0] idle_detach_frames;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic commit_set;
    logic commit_tick;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

>>> src/svpss_ctrl.sv
// ----------------------------------------------------------------------------
// svpss_ctrl
// Sequencer: accepts a request, runs the rounding divider for a set target, commits the result.
// ----------------------------------------------------------------------------
module svpss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tuser,
  output logic              in_tready,
  input  svpss_pkg::sts_t   sts,
  output svpss_pkg::cmd_t   cmd
);
  import svpss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SET  = 5'b01000,
    S_TICK = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [DIV_CW-1:0]  cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = (in_tuser == CMD_TICK) ? S_TICK : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(PW - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SET;
      end
      S_SET: begin
        if (!sts.out_busy) begin
          cmd.commit_set = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_TICK: begin
        if (!sts.out_busy) begin
          cmd.commit_tick = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < DIV_CW'(PW))
    else $error("divider step count out of range");

  a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DIV || state_r == S_TICK))
    else $error("request accepted without starting work");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit_set || cmd.commit_tick) |=> state_r == S_IDLE)
    else $error("commit did not return to idle");
`endif

endmodule

>>> src/svpss_dp.sv
// ----------------------------------------------------------------------------
// svpss_dp
// Datapath: rounding divider, target filters, slew step and result register.
// ----------------------------------------------------------------------------
module svpss_dp #(
  parameter int MAX_PULSE_US = 2500,
  parameter int MIN_PULSE_US = 500
) (
  input  logic             clk,
  input  logic             rst_n,
  input  svpss_pkg::cfg_t  cfg,
  input  svpss_pkg::cmd_t  cmd,
  output svpss_pkg::sts_t  sts,
  input  logic [11:0]      in_req,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata
);
  import svpss_pkg::*;

  localparam logic [PW-1:0]      MAXU = PW'(MAX_PULSE_US);
  localparam logic signed [PW:0] MAXS = (PW+1)'(MAX_PULSE_US);
  localparam logic signed [PW:0] MINS = (PW+1)'(MIN_PULSE_US);
  localparam logic [PW-1:0]      MINU = PW'(MIN_PULSE_US);

  function automatic logic [PW-1:0] absdiff(input logic [PW-1:0] a, input logic [PW-1:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  // effective limits, zero acts as one
  logic [7:0]  q1, mv1, ma1;
  logic [15:0] hf1;
  assign q1  = (cfg.quantum_us == '0) ? 8'd1 : cfg.quantum_us;
  assign mv1 = (cfg.max_velocity_us == '0) ? 8'd1 : cfg.max_velocity_us;
  assign ma1 = (cfg.max_accel_us == '0) ? 8'd1 : cfg.max_accel_us;
  assign hf1 = (cfg.lock_frames == '0) ? 16'd1 : cfg.lock_frames;

  // rounding divider
  logic [PW-1:0] num_r, num_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [PW-1:0] rnd_r;
  logic [PW-1:0] sat_req;
  logic [8:0]    rem_sh;
  logic          ge;

  assign sat_req = (PW'(in_req) > MAXU) ? MAXU : PW'(in_req);
  assign rem_sh  = {rem_r, num_r[PW-1]};
  assign ge      = rem_sh >= {1'b0, q1};

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    if (cmd.load) begin
      num_nxt = sat_req + PW'(q1 >> 1);
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      num_nxt = {num_r[PW-2:0], ge};
      rem_nxt = ge ? 8'(rem_sh - {1'b0, q1}) : rem_sh[7:0];
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (cmd.mul) begin
      rnd_r <= PW'(num_r * q1);
    end
  end

  // channel state
  logic [PW-1:0]     cur_r, tgt_r, held_r;
  logic signed [8:0] vel_r;
  logic [15:0]       sc_r, fsc_r;
  logic              hold_r;

  // set command
  logic [PW-1:0]     s_tgt;
  logic signed [8:0] s_vel;
  logic [15:0]       s_sc, s_fsc;
  logic              s_hold, s_acc, s_block, s_settled;

  always_comb begin
    s_tgt   = tgt_r;
    s_vel   = vel_r;
    s_sc    = sc_r;
    s_fsc   = fsc_r;
    s_hold  = hold_r;
    s_acc   = 1'b0;
    s_block = 1'b0;
    if (hold_r && rnd_r != '0) begin
      if (absdiff(rnd_r, held_r) < PW'(cfg.hold_break_us)) begin
        s_block = 1'b1;
      end else begin
        s_hold = 1'b0;
        s_sc   = '0;
        s_vel  = '0;
      end
    end
    if (!s_block && !(rnd_r != '0 && tgt_r != '0 &&
        absdiff(rnd_r, tgt_r) < PW'(cfg.hysteresis_us))) begin
      s_tgt = rnd_r;
      s_fsc = '0;
      s_acc = 1'b1;
      if (rnd_r == '0) begin
        s_hold = 1'b0;
        s_sc   = '0;
        s_vel  = '0;
      end
    end
    s_settled = (s_tgt == cur_r) && (s_vel == '0) && (s_tgt != '0);
  end

  // frame tick
  logic [PW-1:0]     t_cur, t_tgt, t_held, t_pulse;
  logic signed [8:0] t_vel;
  logic [15:0]       t_sc, t_fsc;
  logic              t_hold, t_settled;
  logic signed [PW:0] err, want, v, val, maxv, maxa, cur_e, tgt_e;

  always_comb begin
    t_cur   = cur_r;
    t_tgt   = tgt_r;
    t_held  = held_r;
    t_vel   = vel_r;
    t_sc    = sc_r;
    t_hold  = hold_r;
    t_pulse = '0;
    maxv    = (PW+1)'(mv1);
    maxa    = (PW+1)'(ma1);
    cur_e   = $signed({1'b0, cur_r});
    tgt_e   = $signed({1'b0, tgt_r});
    err     = tgt_e - cur_e;
    want    = '0;
    v       = '0;
    val     = '0;
    if (hold_r) begin
      t_cur   = held_r;
      t_vel   = '0;
      t_tgt   = held_r;
      t_pulse = held_r;
    end else if (tgt_r == '0) begin
      t_cur  = '0;
      t_vel  = '0;
      t_sc   = '0;
      t_hold = 1'b0;
    end else if (cur_r == '0) begin
      // first target snaps at once
      t_cur   = tgt_r;
      t_vel   = '0;
      t_sc    = '0;
      t_pulse = tgt_r;
    end else if (err == '0) begin
      t_vel = '0;
      t_sc  = (sc_r == 16'hFFFF) ? sc_r : sc_r + 16'd1;
      if (t_sc >= hf1) begin
        t_hold = 1'b1;
        t_held = cur_r;
        t_tgt  = cur_r;
      end
      t_pulse = cur_r;
    end else begin
      t_sc = '0;
      if (err > maxv) begin
        want = maxv;
      end else if (err < -maxv) begin
        want = -maxv;
      end else begin
        want = err;
      end
      v = (PW+1)'(vel_r);
      if (want > v) begin
        v = v + maxa;
        if (v > want) v = want;
      end else if (want < v) begin
        v = v - maxa;
        if (v < want) v = want;
      end
      // no overshoot
      if (err > 0 && v > err) begin
        v = err;
      end else if (err < 0 && v < err) begin
        v = err;
      end
      val = cur_e + v;
      if (val < MINS && tgt_r >= MINU) val = MINS;
      if (val > MAXS) val = MAXS;
      t_cur   = val[PW-1:0];
      t_vel   = v[8:0];
      t_pulse = val[PW-1:0];
    end
    t_fsc     = (fsc_r == 16'hFFFF) ? fsc_r : fsc_r + 16'd1;
    t_settled = (t_tgt == t_cur) && (t_vel == '0) && (t_tgt != '0);
    if (cfg.idle_detach_frames != '0 && t_settled && t_fsc >= cfg.idle_detach_frames) begin
      t_pulse = '0;
    end
    if (t_pulse != '0) begin
      if (t_pulse < MINU) t_pulse = MINU;
      if (t_pulse > MAXU) t_pulse = MAXU;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      tgt_r  <= '0;
      held_r <= '0;
      vel_r  <= '0;
      sc_r   <= '0;
      fsc_r  <= '0;
      hold_r <= 1'b0;
    end else if (cmd.commit_set) begin
      tgt_r  <= s_tgt;
      vel_r  <= s_vel;
      sc_r   <= s_sc;
      fsc_r  <= s_fsc;
      hold_r <= s_hold;
    end else if (cmd.commit_tick) begin
      cur_r  <= t_cur;
      tgt_r  <= t_tgt;
      held_r <= t_held;
      vel_r  <= t_vel;
      sc_r   <= t_sc;
      fsc_r  <= t_fsc;
      hold_r <= t_hold;
    end
  end

  // result register
  logic        ov_r;
  logic [11:0] opulse_r;
  logic        oacc_r, ohold_r, oset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.commit_set || cmd.commit_tick) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_set) begin
      opulse_r <= '0;
      oacc_r   <= s_acc;
      ohold_r  <= s_hold;
      oset_r   <= s_settled;
    end else if (cmd.commit_tick) begin
      opulse_r <= t_pulse[11:0];
      oacc_r   <= 1'b0;
      ohold_r  <= t_hold;
      oset_r   <= t_settled;
    end
  end

  assign sts.out_busy = ov_r && !out_tready;
  assign out_tvalid   = ov_r;
  assign out_tdata    = {1'b0, oset_r, ohold_r, oacc_r, opulse_r};

`ifndef SYNTHESIS
  a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> (tgt_r == held_r && cur_r == held_r && vel_r == '0))
    else $error("hold lock without frozen pulse");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(cmd.commit_set || cmd.commit_tick))
    else $error("result raised without a commit");
`endif

endmodule

>>> src/servo_pulse_slew_shaper_core.sv
// ----------------------------------------------------------------------------
// servo_pulse_slew_shaper_core
// Pulse width shaper for one servo channel with hold lock and idle detach.
// ----------------------------------------------------------------------------
// Requests come in on the in_ channel: in_tuser selects set target (0) or
// frame tick (1), in_tdata carries the requested pulse in microseconds.
// Every request gives exactly one result on the out_ channel.
// A set target passes through the accept state, 13 steps of the serial
// rounding divider, one multiply and one commit. A frame tick goes from
// the accept state straight to its commit. The next request is taken once
// the previous one has committed. The result register lets a new request
// be accepted and worked on while the previous result waits; the commit
// stalls while out_tready is low and the result register is still full.
// The user must write the registers through the cfg_ port only while the
// block is idle; the block itself does not enforce this. After rst_n all
// channel state is zero and the registers take their defaults; the first
// target after reset or release snaps at once.
// ----------------------------------------------------------------------------
module servo_pulse_slew_shaper_core #(
  parameter int MAX_PULSE_US = 2500,
  parameter int MIN_PULSE_US = 500
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [11:0] pulse_request_us
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // in_tuser: [0] command
  input  logic        in_tuser,
  // out_tdata: [11:0] pulse_width_us, [12] target_accepted, [13] hold_active,
  //            [14] is_settled
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import svpss_pkg::*;

  cfg_t       cfg_r;
  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hysteresis_us      <= 10'd60;
      cfg_r.quantum_us         <= 8'd40;
      cfg_r.max_velocity_us    <= 8'd40;
      cfg_r.max_accel_us       <= 8'd2;
      cfg_r.hold_break_us      <= 12'd200;
      cfg_r.lock_frames        <= 16'd10;
      cfg_r.idle_detach_frames <= 16'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HYST:       cfg_r.hysteresis_us      <= cfg_pwdata[9:0];
        REG_QUANTUM:    cfg_r.quantum_us         <= cfg_pwdata[7:0];
        REG_MAX_VEL:    cfg_r.max_velocity_us    <= cfg_pwdata[7:0];
        REG_MAX_ACC:    cfg_r.max_accel_us       <= cfg_pwdata[7:0];
        REG_HOLD_BREAK: cfg_r.hold_break_us      <= cfg_pwdata[11:0];
        REG_HOLD_FRAME: cfg_r.lock_frames        <= cfg_pwdata[15:0];
        REG_IDLE_FRAME: cfg_r.idle_detach_frames <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HYST:       cfg_prdata = 32'(cfg_r.hysteresis_us);
      REG_QUANTUM:    cfg_prdata = 32'(cfg_r.quantum_us);
      REG_MAX_VEL:    cfg_prdata = 32'(cfg_r.max_velocity_us);
      REG_MAX_ACC:    cfg_prdata = 32'(cfg_r.max_accel_us);
      REG_HOLD_BREAK: cfg_prdata = 32'(cfg_r.hold_break_us);
      REG_HOLD_FRAME: cfg_prdata = 32'(cfg_r.lock_frames);
      REG_IDLE_FRAME: cfg_prdata = 32'(cfg_r.idle_detach_frames);
      default:        cfg_prdata = '0;
    endcase
  end

  svpss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  svpss_dp #(
    .MAX_PULSE_US (MAX_PULSE_US),
    .MIN_PULSE_US (MIN_PULSE_US)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (in_tdata[11:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
